/* rtl/core/tpa_pkg.sv */
// Shared types and constants for the triangle primitive assembler.
`default_nettype none
package tpa_pkg;

  // Width of vertex indices, corners and material numbers
  localparam int WORD_BITS = 16;
  // Width of the configuration register index
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_INDEXED_MODE   = 2'd0,
    REG_PRIMITIVE_TYPE = 2'd1,
    REG_VERTEX_BASE    = 2'd2,
    REG_MATERIAL_INDEX = 2'd3
  } cfg_reg_t;

  // Primitive topology codes
  typedef enum logic [1:0] {
    PRIM_LIST    = 2'd0,
    PRIM_STRIP   = 2'd1,
    PRIM_FAN     = 2'd2,
    PRIM_UNKNOWN = 2'd3
  } prim_type_t;

  // Current configuration as seen by the datapath
  typedef struct packed {
    logic                 indexed_mode;
    prim_type_t           primitive_type;
    logic [WORD_BITS-1:0] vertex_base;
    logic [WORD_BITS-1:0] material_index;
  } cfg_t;

  // One input request
  typedef struct packed {
    logic [WORD_BITS-1:0] vertex_index;
    logic                 last_of_surface;
  } in_item_t;

  // One emitted triangle
  typedef struct packed {
    logic [WORD_BITS-1:0] corner_a;
    logic [WORD_BITS-1:0] corner_b;
    logic [WORD_BITS-1:0] corner_c;
    logic [WORD_BITS-1:0] triangle_material;
  } out_item_t;

endpackage
`default_nettype wire

/* rtl/core/tpa_cfg_regs.sv */
// Configuration register file for the triangle primitive assembler.
`default_nettype none
module tpa_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tpa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [tpa_pkg::WORD_BITS-1:0]       cfg_data,
  output tpa_pkg::cfg_t                            cfg
);

  tpa_pkg::cfg_t cfg_r;
  tpa_pkg::cfg_t cfg_nxt;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (tpa_pkg::cfg_reg_t'(cfg_index))
        tpa_pkg::REG_INDEXED_MODE:   cfg_nxt.indexed_mode   = cfg_data[0];
        tpa_pkg::REG_PRIMITIVE_TYPE: cfg_nxt.primitive_type = tpa_pkg::prim_type_t'(cfg_data[1:0]);
        tpa_pkg::REG_VERTEX_BASE:    cfg_nxt.vertex_base    = cfg_data;
        tpa_pkg::REG_MATERIAL_INDEX: cfg_nxt.material_index = cfg_data;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.indexed_mode   <= 1'b0;
      cfg_r.primitive_type <= tpa_pkg::PRIM_LIST;
      cfg_r.vertex_base    <= '0;
      cfg_r.material_index <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/tpa_assembler.sv */
// Input register, surface state and triangle forming for the assembler.
`default_nettype none
module tpa_assembler #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tpa_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tpa_pkg::in_item_t in_data,
  input  wire logic              slot_free,
  output logic                   tri_valid,
  output tpa_pkg::out_item_t     tri_data
);

  localparam int W        = tpa_pkg::WORD_BITS;
  localparam int KeepBits = (INDEX_BITS < W) ? INDEX_BITS : W;
  localparam logic [W-1:0] IndexMask = {W{1'b1}} >> (W - KeepBits);

  // Input register
  logic               in_valid_r;
  tpa_pkg::in_item_t  in_q_r;

  // Surface state; phase_r tracks item_position mod 3
  logic [W-1:0] pos_r,    pos_nxt;
  logic [1:0]   phase_r,  phase_nxt;
  logic [W-1:0] older_r,  older_nxt;
  logic [W-1:0] newer_r,  newer_nxt;
  logic [W-1:0] center_r, center_nxt;

  logic [W-1:0] vtx;
  logic [W-1:0] center_use;
  logic [W-1:0] raw_a, raw_b, raw_c;
  logic         emit;
  logic         advance;
  logic         pos_ge2;

  // Vertex of the current request
  assign vtx        = cfg.indexed_mode ? (in_q_r.vertex_index & IndexMask) : pos_r;
  assign center_use = (pos_r == '0) ? vtx : center_r;
  assign pos_ge2    = (pos_r[W-1:1] != '0);

  // Triangle selection by topology
  always_comb begin
    emit  = 1'b0;
    raw_a = older_r;
    raw_b = newer_r;
    raw_c = vtx;
    case (cfg.primitive_type)
      tpa_pkg::PRIM_LIST: begin
        emit = (phase_r == 2'd2);
      end
      tpa_pkg::PRIM_STRIP: begin
        emit = pos_ge2;
        // odd triangles swap the last two corners
        if (pos_r[0]) begin
          raw_b = vtx;
          raw_c = newer_r;
        end
      end
      tpa_pkg::PRIM_FAN: begin
        emit  = pos_ge2;
        raw_a = center_use;
      end
      default: emit = 1'b0;
    endcase
  end

  // Handshake between input register and output slot
  assign advance   = in_valid_r && (!emit || slot_free);
  assign in_ready  = !in_valid_r || advance;
  assign tri_valid = in_valid_r && emit;

  assign tri_data.corner_a          = raw_a + cfg.vertex_base;
  assign tri_data.corner_b          = raw_b + cfg.vertex_base;
  assign tri_data.corner_c          = raw_c + cfg.vertex_base;
  assign tri_data.triangle_material = cfg.material_index;

  // Next surface state
  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    center_nxt = center_r;
    if (advance) begin
      if (in_q_r.last_of_surface) begin
        pos_nxt    = '0;
        phase_nxt  = 2'd0;
        older_nxt  = '0;
        newer_nxt  = '0;
        center_nxt = '0;
      end else begin
        pos_nxt    = pos_r + 1'b1;
        // 2^16 is 1 mod 3, so the phase restarts at the position wrap
        phase_nxt  = ((&pos_r) || (phase_r == 2'd2)) ? 2'd0 : phase_r + 2'd1;
        older_nxt  = newer_r;
        newer_nxt  = vtx;
        center_nxt = center_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      pos_r      <= '0;
      phase_r    <= 2'd0;
      older_r    <= '0;
      newer_r    <= '0;
      center_r   <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
      center_r <= center_nxt;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/tpa_out_stage.sv */
// Result register holding one triangle until it is taken downstream.
`default_nettype none
module tpa_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               tri_valid,
  input  wire tpa_pkg::out_item_t tri_data,
  output logic                    slot_free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tpa_pkg::out_item_t      out_data
);

  logic               out_valid_r;
  tpa_pkg::out_item_t out_q_r;

  // Slot frees up in the same cycle the held triangle is taken
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= tri_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && tri_valid) begin
      out_q_r <= tri_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/triangle_primitive_assembler.sv */
// Top level of the triangle primitive assembler.
// A request passes the input register, then its triangle the result register.
// Throughput: one request per cycle; the input and result registers stall only
// when a triangle is waiting and the result slot is still occupied.
// Reset (rst_n low, synchronous): configuration, surface state and both valid
// flags return to zero.
`default_nettype none
module triangle_primitive_assembler #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire tpa_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output tpa_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tpa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [tpa_pkg::WORD_BITS-1:0]       cfg_data
);

  tpa_pkg::cfg_t      cfg;
  logic               slot_free;
  logic               tri_valid;
  tpa_pkg::out_item_t tri_data;

  // Configuration registers
  tpa_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Triangle forming
  tpa_assembler #(
    .INDEX_BITS (INDEX_BITS)
  ) u_assembler (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .slot_free (slot_free),
    .tri_valid (tri_valid),
    .tri_data  (tri_data)
  );

  // Result register
  tpa_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .tri_valid (tri_valid),
    .tri_data  (tri_data),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the triangle primitive assembler: directed table, random surfaces.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef tpa_pkg::in_item_t   in_item_t;
  typedef tpa_pkg::out_item_t  out_item_t;
  typedef tpa_pkg::prim_type_t prim_type_t;
  typedef tpa_pkg::cfg_reg_t   cfg_reg_t;

  localparam int WORD_BITS       = tpa_pkg::WORD_BITS;
  localparam int CFG_INDEX_BITS  = tpa_pkg::CFG_INDEX_BITS;
  localparam int CYCLE_LIMIT     = 400_000;
  localparam int RANDOM_VERTICES = 1720;
  localparam int MAX_GAP         = 18;
  localparam int MAX_REPORTS     = 100;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  in_item_t                  in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [WORD_BITS-1:0]      cfg_data  = '0;

  triangle_primitive_assembler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers
  logic                 sh_indexed  = 1'b0;
  prim_type_t           sh_prim     = tpa_pkg::PRIM_LIST;
  logic [WORD_BITS-1:0] sh_base     = '0;
  logic [WORD_BITS-1:0] sh_material = '0;

  // Shadow copy of the surface state
  logic [WORD_BITS-1:0] sh_older  = '0;
  logic [WORD_BITS-1:0] sh_newer  = '0;
  logic [WORD_BITS-1:0] sh_center = '0;
  logic [WORD_BITS-1:0] sh_pos    = '0;

  out_item_t triangles_due[$];
  int        mismatches = 0;
  int        cycles     = 0;
  int        out_hold   = 0;
  bit        calm       = 1'b0;   // no idling on either side while set
  bit        typed_en   = 1'b0;   // current request carries a hand-written triangle
  out_item_t typed_tri  = '0;

  // Directed table: config writes, plain vertices, and vertices with a typed triangle
  typedef enum int {ROW_CFG, ROW_VTX, ROW_TRI} row_kind_t;
  typedef struct {
    row_kind_t            kind;
    cfg_reg_t             sel;
    logic [WORD_BITS-1:0] value;
    logic                 last;
    out_item_t            tri_want;
  } row_t;

  localparam out_item_t NO_TRI = '0;
  // register select of vertex rows, unused
  localparam cfg_reg_t  SEL_NONE = tpa_pkg::REG_INDEXED_MODE;

  row_t plan [30] = '{
    // non-indexed list, reset config
    '{ROW_VTX, SEL_NONE, 16'h1234, 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'hFFFF, 1'b0, NO_TRI},
    '{ROW_TRI, SEL_NONE, 16'h0000, 1'b0, '{16'h0000, 16'h0001, 16'h0002, 16'h0000}},
    // base and material at max, mid-surface; base wraps corners
    '{ROW_CFG, tpa_pkg::REG_MATERIAL_INDEX, 16'hFFFF, 1'b0, NO_TRI},
    '{ROW_CFG, tpa_pkg::REG_VERTEX_BASE,    16'hFFFF, 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'h0001, 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'h8000, 1'b0, NO_TRI},
    '{ROW_TRI, SEL_NONE, 16'h7FFF, 1'b0, '{16'h0002, 16'h0003, 16'h0004, 16'hFFFF}},
    // leftover list vertex dropped at end of surface
    '{ROW_VTX, SEL_NONE, 16'hAAAA, 1'b1, NO_TRI},
    // indexed list with extreme indices
    '{ROW_CFG, tpa_pkg::REG_INDEXED_MODE,   16'h0001, 1'b0, NO_TRI},
    '{ROW_CFG, tpa_pkg::REG_VERTEX_BASE,    16'h0000, 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'hFFFF, 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'h0000, 1'b0, NO_TRI},
    '{ROW_TRI, SEL_NONE, 16'h8001, 1'b0, '{16'hFFFF, 16'h0000, 16'h8001, 16'hFFFF}},
    '{ROW_VTX, SEL_NONE, 16'h5555, 1'b1, NO_TRI},
    // strip: odd triangle swaps its last two corners
    '{ROW_CFG, tpa_pkg::REG_PRIMITIVE_TYPE, 16'(tpa_pkg::PRIM_STRIP), 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'h0010, 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'h0020, 1'b0, NO_TRI},
    '{ROW_TRI, SEL_NONE, 16'h0030, 1'b0, '{16'h0010, 16'h0020, 16'h0030, 16'hFFFF}},
    '{ROW_TRI, SEL_NONE, 16'h0040, 1'b0, '{16'h0020, 16'h0040, 16'h0030, 16'hFFFF}},
    '{ROW_TRI, SEL_NONE, 16'h0050, 1'b1, '{16'h0030, 16'h0040, 16'h0050, 16'hFFFF}},
    // fan keeps the first vertex as center
    '{ROW_CFG, tpa_pkg::REG_PRIMITIVE_TYPE, 16'(tpa_pkg::PRIM_FAN), 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'h0100, 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'h0200, 1'b0, NO_TRI},
    '{ROW_TRI, SEL_NONE, 16'h0300, 1'b0, '{16'h0100, 16'h0200, 16'h0300, 16'hFFFF}},
    '{ROW_TRI, SEL_NONE, 16'h0400, 1'b1, '{16'h0100, 16'h0300, 16'h0400, 16'hFFFF}},
    // unknown topology emits nothing
    '{ROW_CFG, tpa_pkg::REG_PRIMITIVE_TYPE, 16'(tpa_pkg::PRIM_UNKNOWN), 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'h0001, 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'h0002, 1'b0, NO_TRI},
    '{ROW_VTX, SEL_NONE, 16'h0003, 1'b1, NO_TRI}
  };

  function automatic out_item_t make_triangle(logic [WORD_BITS-1:0] a, b, c);
    out_item_t t;
    t.corner_a          = a + sh_base;
    t.corner_b          = b + sh_base;
    t.corner_c          = c + sh_base;
    t.triangle_material = sh_material;
    return t;
  endfunction

  // Advance the shadow surface by one vertex; report the triangle it closes, if any
  function automatic void assemble_vertex(in_item_t item, output bit emits,
                                          output out_item_t tri_out);
    logic [WORD_BITS-1:0] pos;
    logic [WORD_BITS-1:0] v;
    pos     = sh_pos;
    v       = sh_indexed ? item.vertex_index : pos;
    emits   = 1'b0;
    tri_out = '0;
    if (pos == 0) sh_center = v;
    case (sh_prim)
      tpa_pkg::PRIM_LIST: begin
        if (pos % 3 == 2) begin
          emits   = 1'b1;
          tri_out = make_triangle(sh_older, sh_newer, v);
        end
      end
      tpa_pkg::PRIM_STRIP: begin
        if (pos >= 2) begin
          emits   = 1'b1;
          tri_out = pos[0] ? make_triangle(sh_older, v, sh_newer)
                           : make_triangle(sh_older, sh_newer, v);
        end
      end
      tpa_pkg::PRIM_FAN: begin
        if (pos >= 2) begin
          emits   = 1'b1;
          tri_out = make_triangle(sh_center, sh_newer, v);
        end
      end
      default: ;
    endcase
    sh_older = sh_newer;
    sh_newer = v;
    sh_pos   = pos + 1'b1;
    if (item.last_of_surface) begin
      sh_older  = '0;
      sh_newer  = '0;
      sh_center = '0;
      sh_pos    = '0;
    end
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return WORD_BITS'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(string field, logic [WORD_BITS-1:0] want, got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $error("%s: expected %h, got %h", field, want, got);
  endtask

  // Wait until the block has delivered every triangle owed and has gone quiet
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (triangles_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [WORD_BITS-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (sel)
      tpa_pkg::REG_INDEXED_MODE:   sh_indexed  = value[0];
      tpa_pkg::REG_PRIMITIVE_TYPE: sh_prim     = prim_type_t'(value[1:0]);
      tpa_pkg::REG_VERTEX_BASE:    sh_base     = value;
      tpa_pkg::REG_MATERIAL_INDEX: sh_material = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Present one vertex request after a random gap and hold it until accepted
  task automatic push_vertex(in_item_t item, bit pin, out_item_t pinned);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data  <= in_item_t'($bits(in_item_t)'($urandom));
      repeat (gap) @(negedge clk);
    end
    typed_en  = pin;
    typed_tri = pinned;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Predict on every accepted vertex
  always @(posedge clk) begin
    bit        emits;
    out_item_t tri_out;
    if (rst_n && in_valid && in_ready) begin
      assemble_vertex(in_data, emits, tri_out);
      if (typed_en)
        triangles_due = {triangles_due, typed_tri};
      else if (emits)
        triangles_due = {triangles_due, tri_out};
    end
  end

  // Check every accepted triangle against the oldest one owed
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      out_hold <= calm ? 0 : $urandom_range(0, MAX_GAP);
      if (triangles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("triangle with none expected: %h", out_data);
      end else begin
        want = triangles_due.pop_front();
        if (out_data.corner_a !== want.corner_a)
          note_mismatch("corner_a", want.corner_a, out_data.corner_a);
        if (out_data.corner_b !== want.corner_b)
          note_mismatch("corner_b", want.corner_b, out_data.corner_b);
        if (out_data.corner_c !== want.corner_c)
          note_mismatch("corner_c", want.corner_c, out_data.corner_c);
        if (out_data.triangle_material !== want.triangle_material)
          note_mismatch("triangle_material", want.triangle_material,
                        out_data.triangle_material);
      end
    end
  end

  // Result-side stall after each accepted triangle
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold  <= out_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_item_t item;
    int       sent;
    int       len;
    bit       noisy;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].sel, plan[i].value);
      end else begin
        item.vertex_index    = plan[i].value;
        item.last_of_surface = plan[i].last;
        push_vertex(item, plan[i].kind == ROW_TRI, plan[i].tri_want);
      end
    end

    // Random settings, each followed by a handful of surfaces
    while (sent < RANDOM_VERTICES) begin
      write_reg(tpa_pkg::REG_INDEXED_MODE, WORD_BITS'($urandom_range(0, 1)));
      write_reg(tpa_pkg::REG_PRIMITIVE_TYPE, 16'(prim_type_t'($urandom_range(0, 3))));
      write_reg(tpa_pkg::REG_VERTEX_BASE, pick_word());
      write_reg(tpa_pkg::REG_MATERIAL_INDEX, pick_word());
      repeat ($urandom_range(1, 6)) begin
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        calm  = ($urandom_range(0, 3) == 0);
        noisy = ($urandom_range(0, 7) == 0);   // ragged surface boundaries
        for (int k = 0; k < len; k++) begin
          // occasional register change in the middle of a surface
          if ($urandom_range(0, 59) == 0)
            write_reg(cfg_reg_t'($urandom_range(0, 3)), WORD_BITS'($urandom));
          item.vertex_index    = pick_word();
          item.last_of_surface = noisy ? 1'($urandom_range(0, 1)) : (k == len - 1);
          push_vertex(item, 1'b0, NO_TRI);
          sent++;
        end
      end
      calm = 1'b0;
    end

    wait_idle();
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
